@@ sv/kqt_pkg.sv @@
// Shared types and constants for the keyed quantity table.
// Holds request and status codes, controller states and the memory control struct.
// No dependencies; the store, the controller and the top level import this package.
package kqt_pkg;

  localparam int KQT_TABLE_ENTRIES = 64;
  localparam int KQT_DATA_W        = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_UPDATE = 2'd2,
    OP_LIST   = 2'd3
  } kqt_op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } kqt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_SEL,
    S_EMIT
  } kqt_state_t;

  // Enables for the entry memories
  typedef struct packed {
    logic rd_en;
    logic wr_key_en;
    logic wr_qty_en;
  } kqt_mem_ctl_t;

  // One result item
  typedef struct packed {
    kqt_status_t                   status;
    logic signed [KQT_DATA_W-1:0]  entry_key;
    logic signed [KQT_DATA_W-1:0]  quantity;
    logic                          last;
  } kqt_res_t;

endpackage

@@ sv/kqt_if.sv @@
// Valid/ready channel interfaces for request items and result items.
// Standalone; payload widths match the fields of the keyed quantity table.
interface kqt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] key;
  logic signed [31:0] amount;

  modport source (output valid, output op, output key, output amount, input ready);
  modport sink   (input valid, input op, input key, input amount, output ready);
endinterface

interface kqt_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] entry_key;
  logic signed [31:0] quantity;
  logic               last;

  modport source (output valid, output status, output entry_key, output quantity,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_key, input quantity,
                  input last, output ready);
endinterface

@@ sv/kqt_store.sv @@
// Key and quantity memories: one write port, one read port, registered read data.
// Depends on kqt_pkg for the memory control struct.
module kqt_store #(
  parameter int TABLE_ENTRIES = kqt_pkg::KQT_TABLE_ENTRIES,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                                clk,
  input  kqt_pkg::kqt_mem_ctl_t               mem_ctl,
  input  logic [IDX_W-1:0]                    rd_addr,
  input  logic [IDX_W-1:0]                    wr_addr,
  input  logic signed [kqt_pkg::KQT_DATA_W-1:0] wr_key,
  input  logic signed [kqt_pkg::KQT_DATA_W-1:0] wr_qty,
  output logic signed [kqt_pkg::KQT_DATA_W-1:0] rd_key,
  output logic signed [kqt_pkg::KQT_DATA_W-1:0] rd_qty
);
  import kqt_pkg::*;

  logic signed [KQT_DATA_W-1:0] key_mem [TABLE_ENTRIES];
  logic signed [KQT_DATA_W-1:0] qty_mem [TABLE_ENTRIES];
  logic signed [KQT_DATA_W-1:0] rd_key_r;
  logic signed [KQT_DATA_W-1:0] rd_qty_r;

  // Write key and quantity independently
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (mem_ctl.wr_qty_en) begin
      qty_mem[wr_addr] <= wr_qty;
    end
  end

  // Read both memories at one address into the registered read data
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_qty_r <= qty_mem[rd_addr];
    end
  end

  assign rd_key = rd_key_r;
  assign rd_qty = rd_qty_r;

endmodule

@@ sv/kqt_ctrl.sv @@
// Request sequencer: scans the entry memories for a key, writes back inserts and
// updates, and runs selection passes for the sorted dump. Depends on kqt_pkg.
module kqt_ctrl #(
  parameter int TABLE_ENTRIES = kqt_pkg::KQT_TABLE_ENTRIES,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_op,
  input  logic signed [kqt_pkg::KQT_DATA_W-1:0] in_key,
  input  logic signed [kqt_pkg::KQT_DATA_W-1:0] in_amount,
  output logic                                  res_vld,
  input  logic                                  res_rdy,
  output kqt_pkg::kqt_res_t                     res,
  output kqt_pkg::kqt_mem_ctl_t                 mem_ctl,
  output logic [IDX_W-1:0]                      rd_addr,
  output logic [IDX_W-1:0]                      wr_addr,
  output logic signed [kqt_pkg::KQT_DATA_W-1:0] wr_key,
  output logic signed [kqt_pkg::KQT_DATA_W-1:0] wr_qty,
  input  logic signed [kqt_pkg::KQT_DATA_W-1:0] rd_key,
  input  logic signed [kqt_pkg::KQT_DATA_W-1:0] rd_qty
);
  import kqt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  kqt_state_t                 state_r, state_nxt;
  kqt_op_t                    op_r, op_nxt;
  logic signed [KQT_DATA_W-1:0] key_r, key_nxt;
  logic signed [KQT_DATA_W-1:0] amt_r, amt_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           addr_r, addr_nxt;
  logic                       pend_r, pend_nxt;
  logic [IDX_W-1:0]           pidx_r, pidx_nxt;
  logic signed [KQT_DATA_W-1:0] best_key_r, best_key_nxt;
  logic signed [KQT_DATA_W-1:0] best_qty_r, best_qty_nxt;
  logic                       best_vld_r, best_vld_nxt;
  logic signed [KQT_DATA_W-1:0] prev_key_r, prev_key_nxt;
  logic                       have_prev_r, have_prev_nxt;
  logic [CNT_W-1:0]           emitted_r, emitted_nxt;
  kqt_res_t                   res_r, res_nxt;

  logic                       hit;
  logic                       scan_done;
  logic                       cand;
  logic                       full;
  logic signed [KQT_DATA_W-1:0] qty_sum;

  assign hit       = pend_r && (rd_key == key_r);
  assign scan_done = !pend_r && (addr_r >= cnt_r);
  assign full      = (cnt_r == CNT_W'(TABLE_ENTRIES));
  assign qty_sum   = rd_qty + amt_r;
  assign cand      = pend_r && (!have_prev_r || (rd_key > prev_key_r))
                            && (!best_vld_r || (rd_key < best_key_r));

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Request and scan payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    amt_r       <= amt_nxt;
    addr_r      <= addr_nxt;
    pidx_r      <= pidx_nxt;
    best_key_r  <= best_key_nxt;
    best_qty_r  <= best_qty_nxt;
    best_vld_r  <= best_vld_nxt;
    prev_key_r  <= prev_key_nxt;
    have_prev_r <= have_prev_nxt;
    emitted_r   <= emitted_nxt;
    res_r       <= res_nxt;
  end

  // Next state, memory requests and results
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    amt_nxt       = amt_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    best_key_nxt  = best_key_r;
    best_qty_nxt  = best_qty_r;
    best_vld_nxt  = best_vld_r;
    prev_key_nxt  = prev_key_r;
    have_prev_nxt = have_prev_r;
    emitted_nxt   = emitted_r;
    res_nxt       = res_r;
    mem_ctl       = '0;
    rd_addr       = addr_r[IDX_W-1:0];
    wr_addr       = pidx_r;
    wr_key        = key_r;
    wr_qty        = qty_sum;
    in_ready      = 1'b0;
    res_vld       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt        = kqt_op_t'(in_op);
          key_nxt       = in_key;
          amt_nxt       = in_amount;
          addr_nxt      = '0;
          best_vld_nxt  = 1'b0;
          have_prev_nxt = 1'b0;
          emitted_nxt   = '0;
          state_nxt     = (kqt_op_t'(in_op) == OP_LIST) ? S_SEL : S_FIND;
        end
      end

      S_FIND: begin
        res_nxt.entry_key = key_r;
        res_nxt.last      = 1'b1;
        if (hit) begin
          // Key present: report, and write back the sum on update
          state_nxt = S_EMIT;
          priority case (op_r)
            OP_INSERT: begin
              res_nxt.status   = ST_DUP;
              res_nxt.quantity = rd_qty;
            end
            OP_UPDATE: begin
              mem_ctl.wr_qty_en = 1'b1;
              res_nxt.status    = ST_OK;
              res_nxt.quantity  = qty_sum;
            end
            default: begin
              res_nxt.status   = ST_OK;
              res_nxt.quantity = rd_qty;
            end
          endcase
        end else if (scan_done) begin
          // Key absent: append on insert unless full
          state_nxt        = S_EMIT;
          res_nxt.quantity = '0;
          if (op_r == OP_INSERT) begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              mem_ctl.wr_key_en = 1'b1;
              mem_ctl.wr_qty_en = 1'b1;
              wr_addr           = cnt_r[IDX_W-1:0];
              wr_qty            = amt_r;
              cnt_nxt           = cnt_r + CNT_W'(1);
              res_nxt.status    = ST_OK;
              res_nxt.quantity  = amt_r;
            end
          end else begin
            res_nxt.status = ST_NOTFOUND;
          end
        end else if (addr_r < cnt_r) begin
          // Advance the scan by one entry
          mem_ctl.rd_en = 1'b1;
          pend_nxt      = 1'b1;
          pidx_nxt      = addr_r[IDX_W-1:0];
          addr_nxt      = addr_r + CNT_W'(1);
        end
      end

      S_SEL: begin
        // Keep the smallest key above the one last reported
        if (cand) begin
          best_key_nxt = rd_key;
          best_qty_nxt = rd_qty;
          best_vld_nxt = 1'b1;
        end
        if (scan_done) begin
          state_nxt = S_EMIT;
          if (best_vld_r) begin
            res_nxt.status    = ST_OK;
            res_nxt.entry_key = best_key_r;
            res_nxt.quantity  = best_qty_r;
            res_nxt.last      = ((emitted_r + CNT_W'(1)) == cnt_r);
            emitted_nxt       = emitted_r + CNT_W'(1);
          end else begin
            res_nxt.status    = ST_EMPTY;
            res_nxt.entry_key = '0;
            res_nxt.quantity  = '0;
            res_nxt.last      = 1'b1;
          end
        end else if (addr_r < cnt_r) begin
          mem_ctl.rd_en = 1'b1;
          pend_nxt      = 1'b1;
          addr_nxt      = addr_r + CNT_W'(1);
        end
      end

      S_EMIT: begin
        // Hold the result until the output register takes it
        res_vld = 1'b1;
        if (res_rdy) begin
          if (op_r == OP_LIST && !res_r.last) begin
            prev_key_nxt  = res_r.entry_key;
            have_prev_nxt = 1'b1;
            best_vld_nxt  = 1'b0;
            addr_nxt      = '0;
            state_nxt     = S_SEL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

@@ sv/keyed_quantity_table.sv @@
// Keyed quantity table: insert, lookup, update by key, and a sorted dump.
// Insert, lookup and update read the stored entries one at a time (one memory
// read per entry), then write back where needed and report the result; a dump
// runs one full selection pass per result item. One request is in work at a time.
// Reset clears the entry count and the control state; the entry memories are
// not cleared and need no clearing pass.
module keyed_quantity_table #(
  parameter int TABLE_ENTRIES = kqt_pkg::KQT_TABLE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  kqt_in_if.sink     in_ch,
  kqt_out_if.source  out_ch
);
  import kqt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  kqt_mem_ctl_t                 mem_ctl;
  logic [IDX_W-1:0]             rd_addr;
  logic [IDX_W-1:0]             wr_addr;
  logic signed [KQT_DATA_W-1:0] wr_key;
  logic signed [KQT_DATA_W-1:0] wr_qty;
  logic signed [KQT_DATA_W-1:0] rd_key;
  logic signed [KQT_DATA_W-1:0] rd_qty;
  logic                         res_vld;
  logic                         res_rdy;
  kqt_res_t                     res;
  logic                         out_vld_r, out_vld_nxt;
  kqt_res_t                     out_res_r, out_res_nxt;

  kqt_store #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_qty  (wr_qty),
    .rd_key  (rd_key),
    .rd_qty  (rd_qty)
  );

  kqt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .in_key    (in_ch.key),
    .in_amount (in_ch.amount),
    .res_vld   (res_vld),
    .res_rdy   (res_rdy),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_qty    (wr_qty),
    .rd_key    (rd_key),
    .rd_qty    (rd_qty)
  );

  // Output register: load a result when empty or being drained
  assign res_rdy = !out_vld_r || out_ch.ready;

  always_comb begin
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_res_nxt = out_res_r;
    if (res_vld && res_rdy) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.status    = out_res_r.status;
  assign out_ch.entry_key = out_res_r.entry_key;
  assign out_ch.quantity  = out_res_r.quantity;
  assign out_ch.last      = out_res_r.last;

`ifndef SYNTHESIS
  // A new item is never taken while a result is still being offered
  a_accept_not_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !res_vld)
    else $error("item accepted while a result is pending");

  // An offered result holds until the output register takes it
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && !res_rdy) |=> (res_vld && $stable(res)))
    else $error("pending result dropped or changed");

  // Write-back never shares a cycle with a scan read
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.rd_en && (mem_ctl.wr_key_en || mem_ctl.wr_qty_en)))
    else $error("memory read and write in the same cycle");

  // A key is only written together with its quantity
  a_key_with_qty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_key_en |-> mem_ctl.wr_qty_en)
    else $error("key written without quantity");
`endif

endmodule
